// ===== src/lgs_pkg.sv =====
// Shared types and constants for the life generation stream block.
// No dependencies; imported by every module of the block.
package lgs_pkg;

	localparam int ROWS_CFG_W = 11;
	localparam int COLS_CFG_W = 6;

	localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 11'd1024;
	localparam logic [COLS_CFG_W-1:0] COLS_RESET = 6'd32;

	// register index codes, taken from paddr[2]
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [3:0] BIRTH_CNT   = 4'd3;
	localparam logic [3:0] SURVIVE_CNT = 4'd2;

	// three stored rows of one column
	typedef struct packed {
		logic above;
		logic middle;
		logic below;
	} col_t;

	// broadcast to every cell
	typedef struct packed {
		logic clear;
		logic rotate;
		logic below_off;
		logic wr_bit;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		GEN_IDLE,
		GEN_EMIT,
		GEN_FLUSH
	} gen_state_t;

endpackage

// ===== src/lgs_cell.sv =====
// One column of the line stores with its B3/S23 next-state logic.
// Depends on lgs_pkg; chained side by side in life_generation_stream.
module lgs_cell
	import lgs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       wr_en,
	input  col_t       left,
	input  col_t       right,
	output col_t       col,
	output logic       next_bit
);

	logic above_q, middle_q, below_q;
	logic lb, rb, sb;
	logic [3:0] cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q  <= 1'b0;
			middle_q <= 1'b0;
			below_q  <= 1'b0;
		end else if (ctrl.clear) begin
			above_q  <= 1'b0;
			middle_q <= 1'b0;
			below_q  <= 1'b0;
		end else if (ctrl.rotate) begin
			above_q  <= middle_q;
			middle_q <= wr_en ? ctrl.wr_bit : below_q;
			below_q  <= 1'b0;
		end else if (wr_en) begin
			below_q <= ctrl.wr_bit;
		end
	end

	assign col = '{above: above_q, middle: middle_q, below: below_q};

	assign lb = left.below & ~ctrl.below_off;
	assign rb = right.below & ~ctrl.below_off;
	assign sb = below_q & ~ctrl.below_off;

	assign cnt = 4'(left.above) + 4'(left.middle) + 4'(lb)
		+ 4'(right.above) + 4'(right.middle) + 4'(rb)
		+ 4'(above_q) + 4'(sb);

	assign next_bit = (cnt == BIRTH_CNT) || ((cnt == SURVIVE_CNT) && middle_q);

endmodule

// ===== src/lgs_out_fifo.sv =====
// Two-entry result queue between the generator and the output channel.
// Depends on lgs_pkg only by convention; used by life_generation_stream.
module lgs_out_fifo
	import lgs_pkg::*;
#(
	parameter int W = 17
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         room,
	output logic         valid,
	input  logic         ready,
	output logic [W-1:0] data
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         pop;

	assign valid = (cnt_q != 2'd0);
	assign room  = (cnt_q != 2'd2);
	assign pop   = valid & ready;
	assign data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== src/life_generation_stream.sv =====
// Top level of the life generation stream: B3/S23 over a raster cell stream.
// Depends on lgs_pkg, lgs_cell and lgs_out_fifo.
//
// Cells of one generation enter on cell_valid/cell_ready, one word per cell,
// raster order. Results leave on res_valid/res_ready as words of next_alive,
// out_row, out_col, frame_last. Input (r+1,j) releases result (r,j-1), and
// at the last column also (r,j); the last input of a frame releases the
// whole last row, frame_last marking its final cell.
// Throughput: one cell per cycle within a row while the result buffer has room;
// the last cell of rows 1 and up holds cell_ready low while its results go out,
// and the frame end holds it low while the results of the last row go out.
// A result word follows the cell word that releases it through the generator
// state register and then the result buffer, at the earliest.
// Each column is a cell holding three rows; cells feed their column bits to
// their neighbors every cycle and the generator muxes one cell's result.
// Results queue in a two-entry buffer, so a stalled receiver first fills it,
// then cell_ready drops; nothing is lost.
// Reset clears the line stores and counters and sets 1024 rows by 32 columns.
// A configuration write restarts the frame; the user must write only while idle, the block does not enforce it.
module life_generation_stream
	import lgs_pkg::*;
#(
	parameter int MAX_COLS = 32,
	parameter int MAX_ROWS = 1024,
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             cell_valid,
	output logic             cell_ready,
	input  logic             cell_alive,
	output logic             res_valid,
	input  logic             res_ready,
	output logic             next_alive,
	output logic [ROW_W-1:0] out_row,
	output logic [COL_W-1:0] out_col,
	output logic             frame_last
);

	localparam int RCMP_W = ((ROW_W > ROWS_CFG_W) ? ROW_W : ROWS_CFG_W) + 1;
	localparam int RES_W  = 1 + ROW_W + COL_W + 1;

	logic [ROWS_CFG_W-1:0] board_rows_q;
	logic [COLS_CFG_W-1:0] board_cols_q;
	logic                  cfg_wr;

	logic [RCMP_W-1:0]     rows_ext, rows_eff, rows_m1;
	logic [COLS_CFG_W-1:0] cols_eff, cols_m1;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             cell_acc, last_col, last_row, has_emit;

	gen_state_t       gen_st_q, gen_st_n;
	logic [COL_W-1:0] gen_col_q, gen_col_n, gen_end_q, gen_end_n;
	logic [ROW_W-1:0] gen_row_q, gen_row_n;
	logic             rowend_q, rowend_n, flush_q, flush_n;
	logic             push, res_last, fifo_room;

	cell_ctrl_t          ctrl;
	col_t                cols_w [MAX_COLS];
	logic [MAX_COLS-1:0] nxt_bits;
	logic [RES_W-1:0]    push_data, pop_data;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_rows_q <= ROWS_RESET;
			board_cols_q <= COLS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ROWS: board_rows_q <= pwdata[ROWS_CFG_W-1:0];
				REG_COLS: board_cols_q <= pwdata[COLS_CFG_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ROWS: prdata = 32'(board_rows_q);
			REG_COLS: prdata = 32'(board_cols_q);
			default:  prdata = '0;
		endcase
	end

	// clamp sizes into range
	assign rows_ext = RCMP_W'(board_rows_q);
	always_comb begin
		if (rows_ext == '0) rows_eff = RCMP_W'(1);
		else if (rows_ext > RCMP_W'(MAX_ROWS)) rows_eff = RCMP_W'(MAX_ROWS);
		else rows_eff = rows_ext;
		if (board_cols_q == '0) cols_eff = COLS_CFG_W'(1);
		else if (board_cols_q > COLS_CFG_W'(MAX_COLS)) cols_eff = COLS_CFG_W'(MAX_COLS);
		else cols_eff = board_cols_q;
	end
	assign rows_m1 = rows_eff - RCMP_W'(1);
	assign cols_m1 = cols_eff - COLS_CFG_W'(1);

	// input position
	assign cell_acc = cell_valid & cell_ready;
	assign last_col = (COLS_CFG_W'(col_q) == cols_m1);
	assign last_row = (RCMP_W'(row_q) == rows_m1);
	assign has_emit = (row_q != '0) && ((col_q != '0) || last_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_wr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cell_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	assign cell_ready = (gen_st_q == GEN_IDLE)
		|| ((gen_st_q == GEN_EMIT) && !rowend_q && fifo_room);

	// result generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_st_q  <= GEN_IDLE;
			gen_col_q <= '0;
			gen_end_q <= '0;
			gen_row_q <= '0;
			rowend_q  <= 1'b0;
			flush_q   <= 1'b0;
		end else begin
			gen_st_q  <= gen_st_n;
			gen_col_q <= gen_col_n;
			gen_end_q <= gen_end_n;
			gen_row_q <= gen_row_n;
			rowend_q  <= rowend_n;
			flush_q   <= flush_n;
		end
	end

	always_comb begin
		gen_st_n  = gen_st_q;
		gen_col_n = gen_col_q;
		gen_end_n = gen_end_q;
		gen_row_n = gen_row_q;
		rowend_n  = rowend_q;
		flush_n   = flush_q;
		push      = 1'b0;
		res_last  = 1'b0;
		ctrl      = '{clear: cfg_wr, rotate: 1'b0,
			below_off: (gen_st_q == GEN_FLUSH), wr_bit: cell_alive};

		unique case (gen_st_q)
			GEN_IDLE: ;
			GEN_EMIT: begin
				if (fifo_room) begin
					push = 1'b1;
					if (gen_col_q == gen_end_q) begin
						gen_st_n = GEN_IDLE;
						if (rowend_q) begin
							ctrl.rotate = 1'b1;
							if (flush_q) begin
								gen_st_n  = GEN_FLUSH;
								gen_col_n = '0;
								gen_row_n = gen_row_q + ROW_W'(1);
							end
						end
					end else begin
						gen_col_n = gen_col_q + COL_W'(1);
					end
				end
			end
			GEN_FLUSH: begin
				res_last = (COLS_CFG_W'(gen_col_q) == cols_m1);
				if (fifo_room) begin
					push = 1'b1;
					if (res_last) begin
						ctrl.clear = 1'b1;
						gen_st_n   = GEN_IDLE;
					end else begin
						gen_col_n = gen_col_q + COL_W'(1);
					end
				end
			end
			default: gen_st_n = GEN_IDLE;
		endcase

		if (cell_acc) begin
			if (has_emit) begin
				gen_st_n  = GEN_EMIT;
				gen_col_n = (col_q != '0) ? col_q - COL_W'(1) : col_q;
				gen_end_n = last_col ? col_q : col_q - COL_W'(1);
				gen_row_n = row_q - ROW_W'(1);
				rowend_n  = last_col;
				flush_n   = last_col & last_row;
			end else if (last_col) begin
				// first row ends: shift now, single-row board flushes at once
				ctrl.rotate = 1'b1;
				rowend_n    = 1'b0;
				flush_n     = 1'b0;
				if (last_row) begin
					gen_st_n  = GEN_FLUSH;
					gen_col_n = '0;
					gen_row_n = row_q;
				end else begin
					gen_st_n = GEN_IDLE;
				end
			end else begin
				gen_st_n = GEN_IDLE;
			end
		end

		if (cfg_wr) begin
			gen_st_n = GEN_IDLE;
		end
	end

	// row of column cells
	for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
		col_t left_w, right_w;
		if (j == 0) begin : g_l0
			assign left_w = '0;
		end else begin : g_ln
			assign left_w = cols_w[j-1];
		end
		if (j == MAX_COLS - 1) begin : g_r0
			assign right_w = '0;
		end else begin : g_rn
			assign right_w = cols_w[j+1];
		end
		lgs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.wr_en    (cell_acc && (col_q == COL_W'(j))),
			.left     (left_w),
			.right    (right_w),
			.col      (cols_w[j]),
			.next_bit (nxt_bits[j])
		);
	end

	assign push_data = {nxt_bits[gen_col_q], gen_row_q, gen_col_q, res_last};

	lgs_out_fifo #(
		.W (RES_W)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.room      (fifo_room),
		.valid     (res_valid),
		.ready     (res_ready),
		.data      (pop_data)
	);

	assign {next_alive, out_row, out_col, frame_last} = pop_data;

endmodule
